/* rtl/rpcm_pkg.sv */
// ----------------------------------------------------------------------------
// rpcm_pkg: shared types and constants for the RMS / peak / crossing meter
// Holds the sequencer states, register indexes, frame limits and the
// saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcm_pkg;

    localparam int MAX_SAMPLES   = 4096;
    localparam int MAX_CROSSINGS = 100;
    localparam int SAMPLE_BITS   = 12;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int XCNT_W  = $clog2(MAX_CROSSINGS + 1);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int ABS_W   = SAMPLE_BITS + CNT_W - 1;
    localparam int PSUM_W  = 40;

    // form factor reads zero when the mean current is at or below this level, crest factor when the RMS current is
    localparam logic [31:0] MIN_LEVEL = 32'd65;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CURRENT_SCALE   = 2'd0,
        REG_VOLTAGE_SCALE   = 2'd1,
        REG_FALLBACK_PERIOD = 2'd2
    } reg_index_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_IPK,
        ST_MUL_VPK,
        ST_MUL_IABS,
        ST_MUL_VABS,
        ST_DIV_IMEAN,
        ST_LD_VMEAN,
        ST_DIV_VMEAN,
        ST_LD_ISQ,
        ST_DIV_ISQ,
        ST_SQRT_I,
        ST_IRMS_W,
        ST_DIV_VSQ,
        ST_SQRT_V,
        ST_VRMS_W,
        ST_DIV_FF,
        ST_LD_CF,
        ST_DIV_CF,
        ST_LD_PER,
        ST_DIV_PER,
        ST_MUL_PC,
        ST_LD_PH,
        ST_DIV_PH,
        ST_OUT
    } seq_state_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [23:0] sat24(input logic [63:0] v);
        sat24 = (v[63:24] != 40'd0) ? 24'hFF_FFFF : v[23:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rms_peak_crossing_meter.sv */
// ----------------------------------------------------------------------------
// rms_peak_crossing_meter: true RMS, peak and crest factor meter
// Accumulates a frame of current / voltage samples, then computes scaled
// peaks, RMS, mean absolute values, form / crest factor, period and phase.
// ----------------------------------------------------------------------------
//  channel   dir  width  content
//  s_axis    in   56+1   current, voltage, time; tlast ends frame
//  m_axis    out  304+2  one result per frame
//  cfg       in   2+32   scale and fallback period registers
//
//  Samples are taken one per cycle while the meter is idle.
//  After the last sample a sequencer drives one 41x24 multiplier, one
//  restoring divider and a square root unit.
//  s_axis_tready stays low from the last sample until the result is taken.
//  Reset restores the register defaults and clears the frame.
`default_nettype none

module rms_peak_crossing_meter
    import rpcm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [11:0] current_sample, [23:12] voltage_sample, [55:24] sample_time
    input  wire logic [55:0]   s_axis_tdata,
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [31:0] current_peak, [63:32] voltage_peak, [95:64] current_rms,
    // [127:96] voltage_rms, [159:128] current_mean_abs,
    // [191:160] voltage_mean_abs, [215:192] form_factor,
    // [239:216] crest_factor, [271:240] resonance_period,
    // [303:272] phase_degrees
    output logic [303:0]       m_axis_tdata,
    // [0] period_measured, [1] phase_found
    output logic [1:0]         m_axis_tuser,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    // configuration
    logic [23:0] cscale_reg, vscale_reg;
    logic [31:0] fallback_reg;

    // frame state
    logic [CNT_W-1:0]        count_reg;
    logic [SAMPLE_BITS-1:0]  cpk_reg, vpk_reg;
    logic [SQ_W-1:0]         csq_reg, vsq_reg;
    logic [ABS_W-1:0]        cabs_reg, vabs_reg;
    logic signed [SAMPLE_BITS-1:0] cprev_reg, vprev_reg;
    logic [XCNT_W-1:0]       xcnt_reg;
    logic [31:0]             lastx_reg;
    logic [PSUM_W-1:0]       psum_reg;
    logic [XCNT_W-1:0]       pcnt_reg;
    logic [31:0]             fvt_reg, fct_reg;
    logic                    prev_ok_reg, vseen_reg, iseen_reg;

    // sequencer and shared units
    seq_state_t  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic [39:0] rem_reg, rem_next, dvs_reg, dvs_next;
    logic [63:0] quo_reg, quo_next;
    logic [51:0] sx_reg, sx_next;
    logic [25:0] root_reg, root_next;
    logic [27:0] srem_reg, srem_next;

    // results
    logic [31:0] ipk_reg, ipk_next, vpk_res_reg, vpk_res_next;
    logic [31:0] irms_reg, irms_next, vrms_reg, vrms_next;
    logic [31:0] imean_reg, imean_next, vmean_reg, vmean_next;
    logic [23:0] ff_reg, ff_next, cf_reg, cf_next;
    logic [31:0] per_reg, per_next, phase_reg, phase_next;
    logic        valid_reg, valid_next;

    // ------------------------------------------------------------------
    // sample decode and per-sample terms
    logic signed [SAMPLE_BITS-1:0] ci, vi;
    logic [31:0]  t_in;
    logic [SAMPLE_BITS-1:0] ai, av;
    logic         take, acc_en, ix, vx, last_done;

    assign ci   = s_axis_tdata[11:0];
    assign vi   = s_axis_tdata[23:12];
    assign t_in = s_axis_tdata[55:24];
    assign ai   = ci[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ci) : SAMPLE_BITS'(ci);
    assign av   = vi[SAMPLE_BITS-1] ? SAMPLE_BITS'(-vi) : SAMPLE_BITS'(vi);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take   = s_axis_tvalid && s_axis_tready;
    assign acc_en = take && (count_reg < CNT_W'(MAX_SAMPLES));
    assign ix     = prev_ok_reg && (cprev_reg <= 0) && (ci > 0);
    assign vx     = prev_ok_reg && (vprev_reg <= 0) && (vi > 0);
    assign last_done = m_axis_tvalid && m_axis_tready;

    // ------------------------------------------------------------------
    // shared divider step: 64-bit dividend shifts through quo_reg
    logic [40:0] rem_sh, rem_dif;
    logic        dge;
    logic [39:0] rem_step;
    logic [63:0] quo_step;

    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_dif  = rem_sh - {1'b0, dvs_reg};
    assign dge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_step = dge ? rem_dif[39:0] : rem_sh[39:0];
    assign quo_step = {quo_reg[62:0], dge};

    // square root step: two bits of the radicand per cycle
    logic [29:0] srem_sh, trial, srem_dif;
    logic        sge;
    logic [27:0] srem_step;
    logic [25:0] root_step;

    assign srem_sh   = {srem_reg, sx_reg[51:50]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign sge       = srem_sh >= trial;
    assign srem_dif  = srem_sh - trial;
    assign srem_step = sge ? srem_dif[27:0] : srem_sh[27:0];
    assign root_step = {root_reg[24:0], sge};

    // ------------------------------------------------------------------
    // frame-end helpers
    logic [CNT_W-1:0] n_div;
    logic             measured, found, ph_ok, ph_neg;
    logic [31:0]      ph_d;
    logic [63:0]      ph_q;

    assign n_div    = (count_reg != '0) ? count_reg : CNT_W'(1);
    assign measured = (pcnt_reg != '0);
    assign found    = vseen_reg && iseen_reg;
    assign ph_ok    = measured || (fallback_reg != 32'd0);
    assign ph_neg   = fct_reg < fvt_reg;
    assign ph_d     = ph_neg ? (fvt_reg - fct_reg) : (fct_reg - fvt_reg);

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (take && s_axis_tlast) state_next = ST_MUL_IPK;
            ST_MUL_IPK:   state_next = ST_MUL_VPK;
            ST_MUL_VPK:   state_next = ST_MUL_IABS;
            ST_MUL_IABS:  state_next = ST_MUL_VABS;
            ST_MUL_VABS:  state_next = ST_DIV_IMEAN;
            ST_DIV_IMEAN: if (cnt_reg == 7'd1) state_next = ST_LD_VMEAN;
            ST_LD_VMEAN:  state_next = ST_DIV_VMEAN;
            ST_DIV_VMEAN: if (cnt_reg == 7'd1) state_next = ST_LD_ISQ;
            ST_LD_ISQ:    state_next = ST_DIV_ISQ;
            ST_DIV_ISQ:   if (cnt_reg == 7'd1) state_next = ST_SQRT_I;
            ST_SQRT_I:    if (cnt_reg == 7'd1) state_next = ST_IRMS_W;
            ST_IRMS_W:    state_next = ST_DIV_VSQ;
            ST_DIV_VSQ:   if (cnt_reg == 7'd1) state_next = ST_SQRT_V;
            ST_SQRT_V:    if (cnt_reg == 7'd1) state_next = ST_VRMS_W;
            ST_VRMS_W:    state_next = ST_DIV_FF;
            ST_DIV_FF:    if (cnt_reg == 7'd1) state_next = ST_LD_CF;
            ST_LD_CF:     state_next = ST_DIV_CF;
            ST_DIV_CF:    if (cnt_reg == 7'd1) state_next = ST_LD_PER;
            ST_LD_PER:    state_next = ST_DIV_PER;
            ST_DIV_PER:   if (cnt_reg == 7'd1) state_next = ST_MUL_PC;
            ST_MUL_PC:    state_next = ST_LD_PH;
            ST_LD_PH:     state_next = ST_DIV_PH;
            ST_DIV_PH:    if (cnt_reg == 7'd1) state_next = ST_OUT;
            ST_OUT:       if (last_done) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath control per state
    logic [40:0] mul_a;
    logic [23:0] mul_b;
    logic        mul_en;
    logic [64:0] mul_p;
    logic        div_ld;
    logic [63:0] div_a;
    logic [39:0] div_b;

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    always_comb
    begin
        mul_en = 1'b0; mul_a = '0; mul_b = '0;
        div_ld = 1'b0; div_a = '0; div_b = '0;
        cnt_next = cnt_reg;
        rem_next = rem_reg; quo_next = quo_reg; dvs_next = dvs_reg;
        sx_next = sx_reg; root_next = root_reg; srem_next = srem_reg;
        ipk_next = ipk_reg; vpk_res_next = vpk_res_reg;
        irms_next = irms_reg; vrms_next = vrms_reg;
        imean_next = imean_reg; vmean_next = vmean_reg;
        ff_next = ff_reg; cf_next = cf_reg;
        per_next = per_reg; phase_next = phase_reg;
        valid_next = valid_reg;

        case (state_reg)
            ST_MUL_IPK:
            begin
                mul_en = 1'b1; mul_a = 41'(cpk_reg); mul_b = cscale_reg;
            end
            ST_MUL_VPK:
            begin
                ipk_next = sat32(prod_reg);
                mul_en = 1'b1; mul_a = 41'(vpk_reg); mul_b = vscale_reg;
            end
            ST_MUL_IABS:
            begin
                vpk_res_next = sat32(prod_reg);
                mul_en = 1'b1; mul_a = 41'(cabs_reg); mul_b = cscale_reg;
            end
            ST_MUL_VABS:
            begin
                div_ld = 1'b1; div_a = prod_reg; div_b = 40'(n_div);
                mul_en = 1'b1; mul_a = 41'(vabs_reg); mul_b = vscale_reg;
            end
            ST_DIV_IMEAN:
            begin
                if (cnt_reg == 7'd1) imean_next = sat32(quo_step);
            end
            ST_LD_VMEAN:
            begin
                div_ld = 1'b1; div_a = prod_reg; div_b = 40'(n_div);
            end
            ST_DIV_VMEAN:
            begin
                if (cnt_reg == 7'd1) vmean_next = sat32(quo_step);
            end
            ST_LD_ISQ:
            begin
                div_ld = 1'b1; div_a = {13'd0, csq_reg, 16'd0};
                div_b = 40'(n_div);
            end
            ST_DIV_ISQ, ST_DIV_VSQ:
            begin
                if (cnt_reg == 7'd1)
                begin
                    sx_next = quo_step[51:0]; root_next = '0; srem_next = '0;
                end
            end
            ST_SQRT_I:
            begin
                if (cnt_reg == 7'd1)
                begin
                    mul_en = 1'b1; mul_a = 41'(root_step); mul_b = cscale_reg;
                end
            end
            ST_IRMS_W:
            begin
                irms_next = sat32({8'd0, prod_reg[63:8]});
                div_ld = 1'b1; div_a = {13'd0, vsq_reg, 16'd0};
                div_b = 40'(n_div);
            end
            ST_SQRT_V:
            begin
                if (cnt_reg == 7'd1)
                begin
                    mul_en = 1'b1; mul_a = 41'(root_step); mul_b = vscale_reg;
                end
            end
            ST_VRMS_W:
            begin
                vrms_next = sat32({8'd0, prod_reg[63:8]});
                div_ld = 1'b1; div_a = {16'd0, irms_reg, 16'd0};
                div_b = 40'(imean_reg);
            end
            ST_DIV_FF:
            begin
                if (cnt_reg == 7'd1)
                    ff_next = (imean_reg > MIN_LEVEL) ? sat24(quo_step) : 24'd0;
            end
            ST_LD_CF:
            begin
                div_ld = 1'b1; div_a = {16'd0, ipk_reg, 16'd0};
                div_b = 40'(irms_reg);
            end
            ST_DIV_CF:
            begin
                if (cnt_reg == 7'd1)
                    cf_next = (irms_reg > MIN_LEVEL) ? sat24(quo_step) : 24'd0;
            end
            ST_LD_PER:
            begin
                div_ld = 1'b1;
                if (measured)
                begin
                    div_a = {8'd0, psum_reg, 16'd0}; div_b = 40'(pcnt_reg);
                end
                else
                begin
                    div_a = {16'd0, fallback_reg, 16'd0}; div_b = 40'd1;
                end
            end
            ST_DIV_PER:
            begin
                if (cnt_reg == 7'd1) per_next = sat32(quo_step);
                mul_en = 1'b1; mul_a = 41'(ph_d); mul_b = 24'd360;
            end
            ST_MUL_PC:
            begin
                mul_en = 1'b1; mul_a = prod_reg[40:0];
                mul_b = measured ? 24'(pcnt_reg) : 24'd1;
            end
            ST_LD_PH:
            begin
                div_ld = 1'b1; div_a = {prod_reg[47:0], 16'd0};
                div_b = measured ? psum_reg : 40'(fallback_reg);
            end
            ST_DIV_PH:
            begin
                if (cnt_reg == 7'd1)
                begin
                    valid_next = 1'b1;
                    if (!found || !ph_ok)
                        phase_next = 32'd0;
                    else if (ph_neg)
                        phase_next = (quo_step > 64'h8000_0000) ? 32'h8000_0000
                                   : 32'(64'd0 - quo_step);
                    else
                        phase_next = (quo_step > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                   : quo_step[31:0];
                end
            end
            ST_OUT:
            begin
                if (last_done) valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase

        // iterate the divider and root units
        if (state_reg == ST_DIV_IMEAN || state_reg == ST_DIV_VMEAN ||
            state_reg == ST_DIV_ISQ || state_reg == ST_DIV_VSQ ||
            state_reg == ST_DIV_FF || state_reg == ST_DIV_CF ||
            state_reg == ST_DIV_PER || state_reg == ST_DIV_PH)
        begin
            rem_next = rem_step; quo_next = quo_step;
            cnt_next = (cnt_reg == 7'd1 &&
                        (state_reg == ST_DIV_ISQ || state_reg == ST_DIV_VSQ))
                       ? 7'd26 : cnt_reg - 7'd1;
        end
        if (state_reg == ST_SQRT_I || state_reg == ST_SQRT_V)
        begin
            srem_next = srem_step; root_next = root_step;
            sx_next = {sx_reg[49:0], 2'b00};
            cnt_next = cnt_reg - 7'd1;
        end
        if (div_ld)
        begin
            rem_next = '0; quo_next = div_a; dvs_next = div_b; cnt_next = 7'd64;
        end

        prod_next = mul_en ? mul_p[63:0] : prod_reg;
    end

    // ------------------------------------------------------------------
    // control registers, configuration and frame accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= 1'b0;
            cnt_reg      <= '0;
            cscale_reg   <= 24'd65536;
            vscale_reg   <= 24'd65536;
            fallback_reg <= 32'd40;
            count_reg    <= '0;
            cpk_reg      <= '0;
            vpk_reg      <= '0;
            csq_reg      <= '0;
            vsq_reg      <= '0;
            cabs_reg     <= '0;
            vabs_reg     <= '0;
            cprev_reg    <= '0;
            vprev_reg    <= '0;
            xcnt_reg     <= '0;
            lastx_reg    <= '0;
            psum_reg     <= '0;
            pcnt_reg     <= '0;
            fvt_reg      <= '0;
            fct_reg      <= '0;
            prev_ok_reg  <= 1'b0;
            vseen_reg    <= 1'b0;
            iseen_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CURRENT_SCALE:   cscale_reg   <= cfg_data[23:0];
                    REG_VOLTAGE_SCALE:   vscale_reg   <= cfg_data[23:0];
                    REG_FALLBACK_PERIOD: fallback_reg <= cfg_data;
                    default:             ;
                endcase
            end

            if (last_done)
            begin
                // result taken: start a fresh frame
                count_reg   <= '0;
                cpk_reg     <= '0;
                vpk_reg     <= '0;
                csq_reg     <= '0;
                vsq_reg     <= '0;
                cabs_reg    <= '0;
                vabs_reg    <= '0;
                cprev_reg   <= '0;
                vprev_reg   <= '0;
                xcnt_reg    <= '0;
                lastx_reg   <= '0;
                psum_reg    <= '0;
                pcnt_reg    <= '0;
                fvt_reg     <= '0;
                fct_reg     <= '0;
                prev_ok_reg <= 1'b0;
                vseen_reg   <= 1'b0;
                iseen_reg   <= 1'b0;
            end
            else if (acc_en)
            begin
                if (ai > cpk_reg) cpk_reg <= ai;
                if (av > vpk_reg) vpk_reg <= av;
                csq_reg  <= csq_reg + SQ_W'(ai) * SQ_W'(ai);
                vsq_reg  <= vsq_reg + SQ_W'(av) * SQ_W'(av);
                cabs_reg <= cabs_reg + ABS_W'(ai);
                vabs_reg <= vabs_reg + ABS_W'(av);
                if (ix)
                begin
                    if (!iseen_reg)
                    begin
                        fct_reg   <= t_in;
                        iseen_reg <= 1'b1;
                    end
                    if (xcnt_reg < XCNT_W'(MAX_CROSSINGS))
                    begin
                        if (xcnt_reg != '0 && t_in > lastx_reg)
                        begin
                            psum_reg <= psum_reg + PSUM_W'(t_in - lastx_reg);
                            pcnt_reg <= pcnt_reg + XCNT_W'(1);
                        end
                        lastx_reg <= t_in;
                        xcnt_reg  <= xcnt_reg + XCNT_W'(1);
                    end
                end
                if (vx && !vseen_reg)
                begin
                    fvt_reg   <= t_in;
                    vseen_reg <= 1'b1;
                end
                cprev_reg   <= ci;
                vprev_reg   <= vi;
                prev_ok_reg <= 1'b1;
                count_reg   <= count_reg + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        sx_reg      <= sx_next;
        root_reg    <= root_next;
        srem_reg    <= srem_next;
        ipk_reg     <= ipk_next;
        vpk_res_reg <= vpk_res_next;
        irms_reg    <= irms_next;
        vrms_reg    <= vrms_next;
        imean_reg   <= imean_next;
        vmean_reg   <= vmean_next;
        ff_reg      <= ff_next;
        cf_reg      <= cf_next;
        per_reg     <= per_next;
        phase_reg   <= phase_next;
    end

    // result port
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {phase_reg, per_reg, cf_reg, ff_reg, vmean_reg,
                            imean_reg, vrms_reg, irms_reg, vpk_res_reg, ipk_reg};
    assign m_axis_tuser  = {found, measured};

endmodule

`default_nettype wire
